[src/lcs_line_similarity_top_assert.svh]
// Assertion macros shared by the line similarity RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef LCS_LINE_SIMILARITY_TOP_ASSERT_SVH
`define LCS_LINE_SIMILARITY_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define LCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcs assertion failed");

// Next-cycle implication, checked out of reset only.
`define LCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcs assertion failed");

`endif

[src/lcs_pkg.sv]
// Shared types and constants for the line similarity block.
// Used by lcs_cell, lcs_chain and lcs_line_similarity_top; no dependencies.
package lcs_pkg;

  localparam int CHAR_W = 8;
  localparam int THR_W  = 7;
  localparam int CMP_W  = 16;

  localparam logic [CMP_W-1:0] COMPARE_MAX   = 16'hFFFF;
  localparam logic [THR_W-1:0] PERCENT_SCALE = 7'd100;
  localparam logic [THR_W-1:0] THR_RESET     = 7'd60;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STREAM = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              clear;
    logic              load;
    logic [CHAR_W-1:0] chr;
  } lcs_cell_ctl_t;

endpackage

[src/lcs_cell.sv]
// One column of the LCS row: a stored base character and its DP entry.
// Depends on lcs_pkg for the control struct and character width.
module lcs_cell #(
  parameter int LEN_W = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcs_pkg::lcs_cell_ctl_t      ctl,
  input  logic                        load_sel,
  input  logic                        in_tok,
  input  logic [lcs_pkg::CHAR_W-1:0]  in_chr,
  input  logic [LEN_W-1:0]            in_diag,
  input  logic [LEN_W-1:0]            in_left,
  output logic                        out_tok,
  output logic [lcs_pkg::CHAR_W-1:0]  out_chr,
  output logic [LEN_W-1:0]            out_diag,
  output logic [LEN_W-1:0]            out_left
);

  logic [lcs_pkg::CHAR_W-1:0] base_r;
  logic                       used_r;
  logic [LEN_W-1:0]           dp_r;
  logic                       tok_r;
  logic [lcs_pkg::CHAR_W-1:0] chr_r;
  logic [LEN_W-1:0]           diag_r;
  logic [LEN_W-1:0]           left_r;
  logic [LEN_W-1:0]           val;

  // An unused column passes the left value straight through, so the last
  // cell always presents the entry of the last stored base character.
  always_comb begin
    if (!used_r) begin
      val = in_left;
    end else if (base_r == in_chr) begin
      val = in_diag + LEN_W'(1);
    end else if (in_left > dp_r) begin
      val = in_left;
    end else begin
      val = dp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && load_sel) begin
      base_r <= ctl.chr;
    end
    if (in_tok) begin
      chr_r <= in_chr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      used_r <= 1'b0;
      dp_r   <= '0;
      tok_r  <= 1'b0;
      diag_r <= '0;
      left_r <= '0;
    end else begin
      tok_r <= in_tok;
      if (ctl.load && load_sel) begin
        used_r <= 1'b1;
      end
      if (in_tok) begin
        dp_r   <= val;
        diag_r <= dp_r;
        left_r <= val;
      end
    end
  end

  assign out_tok  = tok_r;
  assign out_chr  = chr_r;
  assign out_diag = diag_r;
  assign out_left = left_r;

endmodule

[src/lcs_chain.sv]
// Row of lcs_cell instances; compare characters ripple one cell per cycle.
// Depends on lcs_pkg and lcs_cell.
module lcs_chain #(
  parameter int MAX_LINE = 256,
  parameter int LEN_W    = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcs_pkg::lcs_cell_ctl_t      ctl,
  input  logic [LEN_W-1:0]            base_len,
  input  logic                        head_tok,
  input  logic [lcs_pkg::CHAR_W-1:0]  head_chr,
  output logic [LEN_W-1:0]            tail_left
);

  logic                       tok  [0:MAX_LINE];
  logic [lcs_pkg::CHAR_W-1:0] chr  [0:MAX_LINE];
  logic [LEN_W-1:0]           diag [0:MAX_LINE];
  logic [LEN_W-1:0]           left [0:MAX_LINE];

  assign tok[0]  = head_tok;
  assign chr[0]  = head_chr;
  assign diag[0] = '0;
  assign left[0] = '0;

  for (genvar k = 0; k < MAX_LINE; k++) begin : g_cell
    logic sel;
    assign sel = (base_len == LEN_W'(k));

    lcs_cell #(
      .LEN_W(LEN_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .load_sel(sel),
      .in_tok  (tok[k]),
      .in_chr  (chr[k]),
      .in_diag (diag[k]),
      .in_left (left[k]),
      .out_tok (tok[k+1]),
      .out_chr (chr[k+1]),
      .out_diag(diag[k+1]),
      .out_left(left[k+1])
    );
  end

  assign tail_left = left[MAX_LINE];

endmodule

[src/lcs_line_similarity_top.sv]
// Line similarity by LCS length: a systolic row of cells plus the pair sequencer.
// Depends on lcs_pkg, lcs_chain and lcs_line_similarity_top_assert.svh.
//
// Usage: write the threshold (whole percent) on cfg_wr_data with cfg_wr_en
// while idle; it resets to 60. Items arrive on in_valid/in_stall with in_op
// and in_char_code. Load items store base characters, one per cell; those
// beyond MAX_LINE are dropped and flagged. Stream items enter the cell row
// and are accepted one per cycle while in_stall is low; each moves one
// cell along per cycle. An end item stalls the input while the last stream
// character leaves the row, then the result (similar, lcs_length,
// base_truncated) is placed in the output register and the pair state is
// cleared. A new pair may be loaded while that result waits; if out_stall
// holds off an earlier result, the next end item waits until it is taken.
// Load, stream and unused items do not stall the input; an end item does.
// Reset (rst_n low, synchronous) empties the pair and clears out_valid.
`include "lcs_line_similarity_top_assert.svh"

module lcs_line_similarity_top #(
  parameter int MAX_LINE = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lcs_pkg::THR_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [lcs_pkg::CHAR_W-1:0]  in_char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_similar,
  output logic [$clog2(MAX_LINE+1)-1:0] out_lcs_length,
  output logic                        out_base_truncated
);

  localparam int LEN_W  = $clog2(MAX_LINE + 1);
  localparam int CNT_W  = $clog2(MAX_LINE);
  localparam int WIDE_W = (LEN_W > lcs_pkg::CMP_W) ? LEN_W : lcs_pkg::CMP_W;
  localparam int PROD_W = WIDE_W + lcs_pkg::THR_W;

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [LEN_W-1:0]            base_len_r, base_len_nxt;
  logic [lcs_pkg::CMP_W-1:0]   comp_len_r, comp_len_nxt;
  logic                        trunc_r, trunc_nxt;
  logic [lcs_pkg::THR_W-1:0]   thr_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        sim_r, sim_nxt;
  logic [LEN_W-1:0]            lcs_r, lcs_nxt;
  logic                        otrunc_r, otrunc_nxt;

  logic                        in_acc;
  logic                        stream_acc;
  logic                        finish;
  logic [LEN_W-1:0]            tail_left;
  lcs_pkg::lcs_cell_ctl_t      ctl;
  logic [PROD_W-1:0]           scaled, lim_m, lim_n;

  assign in_stall   = (state_r == ST_DRAIN);
  assign in_acc     = in_valid && !in_stall;
  assign stream_acc = in_acc && (in_op == lcs_pkg::OP_STREAM);
  assign finish     = (state_r == ST_DRAIN) && (cnt_r == CNT_W'(MAX_LINE - 1))
                      && (!out_valid_r || !out_stall);

  assign scaled = PROD_W'(tail_left) * PROD_W'(lcs_pkg::PERCENT_SCALE);
  assign lim_m  = PROD_W'(thr_r) * PROD_W'(base_len_r);
  assign lim_n  = PROD_W'(thr_r) * PROD_W'(comp_len_r);

  always_comb begin
    ctl.clear     = finish;
    ctl.load      = 1'b0;
    ctl.chr       = in_char_code;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    base_len_nxt  = base_len_r;
    comp_len_nxt  = comp_len_r;
    trunc_nxt     = trunc_r;
    out_valid_nxt = out_valid_r && out_stall;
    sim_nxt       = sim_r;
    lcs_nxt       = lcs_r;
    otrunc_nxt    = otrunc_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            lcs_pkg::OP_LOAD: begin
              if (comp_len_r == '0) begin
                if (base_len_r < LEN_W'(MAX_LINE)) begin
                  ctl.load     = 1'b1;
                  base_len_nxt = base_len_r + LEN_W'(1);
                end else begin
                  trunc_nxt = 1'b1;
                end
              end
            end
            lcs_pkg::OP_STREAM: begin
              if (comp_len_r != lcs_pkg::COMPARE_MAX) begin
                comp_len_nxt = comp_len_r + lcs_pkg::CMP_W'(1);
              end
            end
            lcs_pkg::OP_END: begin
              state_nxt = ST_DRAIN;
              cnt_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (cnt_r != CNT_W'(MAX_LINE - 1)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (finish) begin
          out_valid_nxt = 1'b1;
          lcs_nxt       = tail_left;
          otrunc_nxt    = trunc_r;
          sim_nxt       = (base_len_r != '0) && (comp_len_r != '0)
                          && (scaled >= lim_m) && (scaled >= lim_n);
          base_len_nxt  = '0;
          comp_len_nxt  = '0;
          trunc_nxt     = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      base_len_r  <= '0;
      comp_len_r  <= '0;
      trunc_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      base_len_r  <= base_len_nxt;
      comp_len_r  <= comp_len_nxt;
      trunc_r     <= trunc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sim_r    <= sim_nxt;
    lcs_r    <= lcs_nxt;
    otrunc_r <= otrunc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= lcs_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  lcs_chain #(
    .MAX_LINE(MAX_LINE),
    .LEN_W   (LEN_W)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .base_len (base_len_r),
    .head_tok (stream_acc),
    .head_chr (in_char_code),
    .tail_left(tail_left)
  );

  assign out_valid          = out_valid_r;
  assign out_similar        = sim_r;
  assign out_lcs_length     = lcs_r;
  assign out_base_truncated = otrunc_r;

  // The overflow flag can only be set once every cell holds a character.
  `LCS_ASSERT_IMP(a_trunc_full, trunc_r, base_len_r == LEN_W'(MAX_LINE))
  // A result only appears at the end of a drain.
  `LCS_ASSERT_IMP(a_result_after_drain, $rose(out_valid_r), $past(state_r == ST_DRAIN))
  // Finishing a pair leaves it empty and the sequencer idle.
  `LCS_ASSERT_NXT(a_pair_cleared, finish,
                  base_len_r == '0 && comp_len_r == '0 && state_r == ST_IDLE)
  // Base loads after the first compare character leave the base length alone.
  `LCS_ASSERT_NXT(a_late_load_ignored,
                  in_acc && in_op == lcs_pkg::OP_LOAD && comp_len_r != '0,
                  base_len_r == $past(base_len_r))

endmodule
